FILE: sv/assert_macros.svh
// Assertion macros used by the tuner RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/pdst_pkg.sv
// Package: types and constants of the PWM duty sweep tuner
`default_nettype none

package pdst_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_START_PEAK  = 2'd0;
  localparam logic [1:0] OP_START_LEVEL = 2'd1;
  localparam logic [1:0] OP_SAMPLE      = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SWEEP_START  = 2'd0;
  localparam logic [1:0] REG_SWEEP_END    = 2'd1;
  localparam logic [1:0] REG_DROP_LIMIT   = 2'd2;
  localparam logic [1:0] REG_LEVEL_TARGET = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_SWEEP_START  = 8'd85;
  localparam logic [7:0] RST_SWEEP_END    = 8'd180;
  localparam logic [7:0] RST_DROP_LIMIT   = 8'd10;
  localparam logic [7:0] RST_LEVEL_TARGET = 8'd138;

  // Reset duty value
  localparam logic [7:0] RST_DUTY = 8'd85;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PEAK   = 2'd1,
    MODE_LCHECK = 2'd2,
    MODE_LSWEEP = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] sample;
  } pdst_in_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       busy_res;
    logic       finished;
    logic [7:0] found_duty;
  } pdst_out_t;

endpackage

`default_nettype wire

FILE: sv/pwm_duty_sweep_tuner.sv
// PWM duty sweep tuner: top level with input register, sweep logic and result register
//
// Use: send items on in_valid/in_ready/in_data. An item either starts a
// peak search, starts a level search, or delivers the current sample
// measured at the duty last output. Each accepted item yields exactly one
// result on out_valid/out_ready/out_data: the duty to apply now, whether
// the sweep still waits for samples, whether this item ended a sweep, and
// the answer (duty found, or 0 for failure).
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while no
// item is in flight; a write lands at the clock edge, without wait.
// An accepted item is captured in the input register; its result is loaded
// into the result register when the input register advances.
// Throughput: one item per cycle when the receiver does not stall; the sweep state
// is read and updated by one compare-and-select pass between the two registers.
// Reset (rst_n low, synchronous): registers return to 85/180/10/138, duty
// to 85, the sweep to idle, and both registers to empty.
// Receiver stall: the result register holds its item, the input register
// holds the next one, and in_ready falls once both are full.
`default_nettype none

module pwm_duty_sweep_tuner
  import pdst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pdst_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pdst_out_t      out_data,
  input  wire logic      cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

`include "assert_macros.svh"

  // Configuration registers
  logic [7:0] sweep_start_r, sweep_end_r, drop_limit_r, level_target_r;

  // Sweep state
  mode_t      mode_r, mode_nxt;
  logic [7:0] duty_r, duty_nxt;
  logic [7:0] peak_sample_r, peak_sample_nxt;
  logic [7:0] peak_duty_r, peak_duty_nxt;

  // Pipeline registers
  logic       s1_vld_r;
  pdst_in_t   s1_item_r;
  logic       out_vld_r;
  pdst_out_t  out_r, out_nxt;
  logic       s1_adv;

  // Decision flags
  logic [7:0] smp;
  logic       peak_upd, drop_hit, at_end, level_hit, range_bad;
  logic [7:0] peak_cand, pduty_cand;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_start_r  <= RST_SWEEP_START;
      sweep_end_r    <= RST_SWEEP_END;
      drop_limit_r   <= RST_DROP_LIMIT;
      level_target_r <= RST_LEVEL_TARGET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SWEEP_START:  sweep_start_r  <= cfg_wdata;
        REG_SWEEP_END:    sweep_end_r    <= cfg_wdata;
        REG_DROP_LIMIT:   drop_limit_r   <= cfg_wdata;
        REG_LEVEL_TARGET: level_target_r <= cfg_wdata;
        default:          sweep_start_r  <= sweep_start_r;
      endcase
    end
  end

  // Handshake: advance the input register when the result register frees up
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Compare flags shared by mode and datapath logic
  assign smp        = s1_item_r.sample;
  assign peak_upd   = smp > peak_sample_r;
  assign peak_cand  = peak_upd ? smp : peak_sample_r;
  assign pduty_cand = peak_upd ? duty_r : peak_duty_r;
  assign drop_hit   = (peak_cand - smp) > drop_limit_r;
  assign at_end     = duty_r >= sweep_end_r;
  assign level_hit  = smp >= level_target_r;
  assign range_bad  = sweep_start_r > sweep_end_r;

  // Next sweep mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (s1_item_r.operation)
      OP_START_PEAK:  mode_nxt = range_bad ? MODE_IDLE : MODE_PEAK;
      OP_START_LEVEL: mode_nxt = MODE_LCHECK;
      OP_SAMPLE: begin
        unique case (mode_r)
          MODE_PEAK:   mode_nxt = (drop_hit || at_end) ? MODE_IDLE : MODE_PEAK;
          MODE_LCHECK: mode_nxt = (level_hit || range_bad) ? MODE_IDLE : MODE_LSWEEP;
          MODE_LSWEEP: mode_nxt = (level_hit || at_end) ? MODE_IDLE : MODE_LSWEEP;
          default:     mode_nxt = MODE_IDLE;
        endcase
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // Datapath and result
  always_comb begin
    duty_nxt            = duty_r;
    peak_sample_nxt     = peak_sample_r;
    peak_duty_nxt       = peak_duty_r;
    out_nxt.finished    = 1'b0;
    out_nxt.found_duty  = 8'd0;
    unique case (s1_item_r.operation)
      OP_START_PEAK: begin
        peak_sample_nxt = 8'd0;
        peak_duty_nxt   = 8'd0;
        if (range_bad) begin
          out_nxt.finished = 1'b1;
        end else begin
          duty_nxt = sweep_start_r;
        end
      end
      OP_START_LEVEL: begin
        duty_nxt = sweep_start_r;
      end
      OP_SAMPLE: begin
        unique case (mode_r)
          MODE_PEAK: begin
            peak_sample_nxt = peak_cand;
            peak_duty_nxt   = pduty_cand;
            if (drop_hit) begin
              duty_nxt           = pduty_cand;
              out_nxt.found_duty = pduty_cand;
              out_nxt.finished   = 1'b1;
            end else if (at_end) begin
              out_nxt.finished = 1'b1;
            end else begin
              duty_nxt = duty_r + 8'd1;
            end
          end
          MODE_LCHECK: begin
            out_nxt.finished = level_hit || range_bad;
          end
          MODE_LSWEEP: begin
            if (level_hit) begin
              out_nxt.found_duty = duty_r;
              out_nxt.finished   = 1'b1;
            end else if (at_end) begin
              out_nxt.finished = 1'b1;
            end else begin
              duty_nxt = duty_r + 8'd1;
            end
          end
          default: begin
            duty_nxt = duty_r;
          end
        endcase
      end
      default: begin
        duty_nxt = duty_r;
      end
    endcase
    out_nxt.duty     = duty_nxt;
    out_nxt.busy_res = (mode_nxt != MODE_IDLE);
  end

  // Update sweep state on each advancing item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      duty_r        <= RST_DUTY;
      peak_sample_r <= 8'd0;
      peak_duty_r   <= 8'd0;
    end else if (s1_adv) begin
      mode_r        <= mode_nxt;
      duty_r        <= duty_nxt;
      peak_sample_r <= peak_sample_nxt;
      peak_duty_r   <= peak_duty_nxt;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A finished sweep never reports busy
  `ASSERT_IMPL(a_fin_not_busy, clk, rst_n, out_vld_r && out_r.finished, !out_r.busy_res)
  // A nonzero answer only comes with a finished sweep
  `ASSERT_IMPL(a_found_fin, clk, rst_n, out_vld_r && (out_r.found_duty != 8'd0),
    out_r.finished)
  // The held result's busy flag matches the live sweep mode
  `ASSERT_IMPL(a_busy_mode, clk, rst_n, out_vld_r, out_r.busy_res == (mode_r != MODE_IDLE))
  // An empty result register never blocks the input
  `ASSERT_IMPL(a_ready_empty, clk, rst_n, !out_vld_r, in_ready)
  // An advancing item always leaves a result behind
  `ASSERT_NEXT(a_adv_result, clk, rst_n, s1_adv, out_vld_r)

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the PWM duty sweep tuner
`timescale 1ns / 100ps

module testbench
  import pdst_pkg::*;
();

  // Operation code that the block ignores
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int ITEM_GOAL = 550;
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pdst_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pdst_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  // Tuner state as the predictor sees it
  logic [7:0] reg_start = RST_SWEEP_START;
  logic [7:0] reg_end = RST_SWEEP_END;
  logic [7:0] reg_drop = RST_DROP_LIMIT;
  logic [7:0] reg_target = RST_LEVEL_TARGET;
  logic [7:0] tuned_duty = RST_DUTY;
  mode_t sweep_state = MODE_IDLE;
  logic [7:0] best_sample = '0;
  logic [7:0] best_duty = '0;

  pdst_out_t pending_duty_reports[$];

  // Run control and statistics
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int long_hold = 0;
  int active_items = 0;
  int ignored_items = 0;
  int reports_checked = 0;
  int sweeps_ended = 0;
  int settings_applied = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  pwm_duty_sweep_tuner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Advance the sweep state by one item and return the report it causes
  function automatic pdst_out_t predict_tuner_step(input pdst_in_t item);
    pdst_out_t rep;
    logic done;
    logic [7:0] answer;
    done = 1'b0;
    answer = '0;
    case (item.operation)
      OP_START_PEAK: begin
        best_sample = '0;
        best_duty = '0;
        if (reg_start > reg_end) begin
          sweep_state = MODE_IDLE;
          done = 1'b1;
        end else begin
          tuned_duty = reg_start;
          sweep_state = MODE_PEAK;
        end
      end
      OP_START_LEVEL: begin
        tuned_duty = reg_start;
        sweep_state = MODE_LCHECK;
      end
      OP_SAMPLE: begin
        case (sweep_state)
          MODE_PEAK: begin
            if (item.sample > best_sample) begin
              best_sample = item.sample;
              best_duty = tuned_duty;
            end
            if (best_sample - item.sample > reg_drop) begin
              tuned_duty = best_duty;
              answer = best_duty;
              done = 1'b1;
              sweep_state = MODE_IDLE;
            end else if (tuned_duty >= reg_end) begin
              done = 1'b1;
              sweep_state = MODE_IDLE;
            end else begin
              tuned_duty = tuned_duty + 8'd1;
            end
          end
          MODE_LCHECK: begin
            if (item.sample >= reg_target || reg_start > reg_end) begin
              done = 1'b1;
              sweep_state = MODE_IDLE;
            end else begin
              sweep_state = MODE_LSWEEP;
            end
          end
          MODE_LSWEEP: begin
            if (item.sample >= reg_target) begin
              answer = tuned_duty;
              done = 1'b1;
              sweep_state = MODE_IDLE;
            end else if (tuned_duty >= reg_end) begin
              done = 1'b1;
              sweep_state = MODE_IDLE;
            end else begin
              tuned_duty = tuned_duty + 8'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (done) sweeps_ended++;
    rep.duty = tuned_duty;
    rep.busy_res = (sweep_state != MODE_IDLE);
    rep.finished = done;
    rep.found_duty = answer;
    return rep;
  endfunction

  // Offer one item (after a random gap when send_idle is set), hold it until accepted, then predict
  task automatic send_item(input logic [1:0] op, input logic [7:0] smp);
    int gap;
    pdst_in_t item;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    item.operation = op;
    item.sample = smp;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op == OP_IGNORED || (op == OP_SAMPLE && sweep_state == MODE_IDLE))
      ignored_items++;
    else
      active_items++;
    pending_duty_reports.push_back(predict_tuner_step(item));
  endtask

  // Drop valid and hold until every predicted report has arrived
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_duty_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write all four registers while nothing is in flight
  task automatic set_config(input logic [7:0] start_v, input logic [7:0] end_v,
                            input logic [7:0] drop_v, input logic [7:0] target_v);
    wait_all_results();
    write_register(REG_SWEEP_START, start_v);
    write_register(REG_SWEEP_END, end_v);
    write_register(REG_DROP_LIMIT, drop_v);
    write_register(REG_LEVEL_TARGET, target_v);
    cfg_wr_en <= 1'b0;
    reg_start = start_v;
    reg_end = end_v;
    reg_drop = drop_v;
    reg_target = target_v;
    settings_applied++;
  endtask

  // Compare one report against the oldest prediction
  task automatic check_duty_report(input pdst_out_t got);
    pdst_out_t want;
    reports_checked++;
    if (pending_duty_reports.size() == 0) begin
      mismatches++;
      $error("unexpected result: duty %0d busy %0d finished %0d found %0d",
             got.duty, got.busy_res, got.finished, got.found_duty);
      return;
    end
    want = pending_duty_reports.pop_front();
    if (got.duty !== want.duty) begin
      mismatches++;
      $error("duty: expected %0d, got %0d", want.duty, got.duty);
    end
    if (got.busy_res !== want.busy_res) begin
      mismatches++;
      $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
    end
    if (got.finished !== want.finished) begin
      mismatches++;
      $error("finished: expected %0d, got %0d", want.finished, got.finished);
    end
    if (got.found_duty !== want.found_duty) begin
      mismatches++;
      $error("found_duty: expected %0d, got %0d", want.found_duty, got.found_duty);
    end
  endtask

  function automatic int clamp_level(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // Sample and unused-operation items while no sweep runs
  task automatic test_idle_items();
    send_item(OP_SAMPLE, 8'd255);
    send_item(OP_IGNORED, 8'hAA);
  endtask

  // Rise to a peak, then fall by more than the drop limit
  task automatic test_peak_search();
    send_item(OP_START_PEAK, 8'h55);
    send_item(OP_SAMPLE, 8'd10);
    send_item(OP_SAMPLE, 8'd255);
    send_item(OP_SAMPLE, 8'd250);
    send_item(OP_SAMPLE, 8'd244);
  endtask

  // Fail at the start check, then reach the target exactly
  task automatic test_level_search();
    send_item(OP_START_LEVEL, 8'd0);
    send_item(OP_SAMPLE, 8'd200);
    send_item(OP_START_LEVEL, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
    send_item(OP_SAMPLE, 8'd138);
  endtask

  // Start a new sweep on top of a running one
  task automatic test_sweep_restart();
    send_item(OP_START_PEAK, 8'd0);
    send_item(OP_SAMPLE, 8'd30);
    send_item(OP_START_LEVEL, 8'd255);
    send_item(OP_SAMPLE, 8'd255);
  endtask

  // Inverted range, peak at duty zero and sweeps that run into the top value
  task automatic test_register_extremes();
    set_config(8'd200, 8'd100, 8'd10, 8'd138);
    send_item(OP_START_PEAK, 8'd0);
    send_item(OP_START_LEVEL, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
    set_config(8'd0, 8'd255, 8'd0, 8'd255);
    send_item(OP_START_PEAK, 8'd0);
    send_item(OP_SAMPLE, 8'd5);
    send_item(OP_SAMPLE, 8'd4);
    send_item(OP_START_LEVEL, 8'd0);
    send_item(OP_SAMPLE, 8'd255);
    set_config(8'd254, 8'd255, 8'd255, 8'd255);
    send_item(OP_START_PEAK, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
    send_item(OP_START_LEVEL, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
    send_item(OP_SAMPLE, 8'd0);
  endtask

  // Hold off the receiver while a long level sweep keeps the input busy
  task automatic test_receiver_hold();
    set_config(RST_SWEEP_START, RST_SWEEP_END, RST_DROP_LIMIT, RST_LEVEL_TARGET);
    send_idle = 1'b0;
    long_hold = 150;
    send_item(OP_START_LEVEL, 8'($urandom_range(0, 255)));
    send_item(OP_SAMPLE, 8'($urandom_range(0, 137)));
    repeat (30) send_item(OP_SAMPLE, 8'($urandom_range(0, 137)));
    send_item(OP_SAMPLE, 8'($urandom_range(138, 255)));
    send_idle = 1'b1;
  endtask

  // One sweep with shaped samples, mixed with noise, restarts and pauses
  task automatic run_sweep(input bit peak_kind);
    int lvl;
    int steps;
    int turn;
    int pick;
    send_item(peak_kind ? OP_START_PEAK : OP_START_LEVEL, 8'($urandom_range(0, 255)));
    lvl = $urandom_range(0, 120);
    turn = $urandom_range(0, 20);
    steps = 0;
    while (sweep_state != MODE_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(OP_IGNORED, 8'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        send_item($urandom_range(0, 1) ? OP_START_PEAK : OP_START_LEVEL,
                  8'($urandom_range(0, 255)));
        steps = 0;
      end else if (pick < 6) begin
        wait_all_results();
      end else if (pick < 14) begin
        send_item(OP_SAMPLE, 8'($urandom_range(0, 255)));
      end else begin
        // shape the sample after the kind of sweep that runs
        case (sweep_state)
          MODE_PEAK: begin
            if (steps < turn)
              lvl = clamp_level(lvl + $urandom_range(0, 12));
            else
              lvl = clamp_level(lvl - $urandom_range(0, reg_drop / 2 + 6));
          end
          MODE_LCHECK: begin
            if ($urandom_range(0, 3) == 0)
              lvl = $urandom_range(reg_target, 255);
            else
              lvl = (reg_target == 0) ? 0 : $urandom_range(0, reg_target - 1);
          end
          default: lvl = clamp_level(lvl + $urandom_range(0, 10));
        endcase
        send_item(OP_SAMPLE, 8'(lvl));
        steps++;
      end
    end
  endtask

  // Pick a setting: mostly short ranges, sometimes the extremes
  task automatic random_config();
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] d;
    logic [7:0] t;
    int pick;
    pick = $urandom_range(0, 9);
    d = 8'($urandom_range(0, 40));
    case (pick)
      0: begin s = 8'd0; e = 8'd255; end
      1: begin s = 8'd255; e = 8'd0; end
      2: begin s = 8'($urandom_range(0, 255)); e = s; end
      3: begin s = 8'($urandom_range(240, 255)); e = 8'd255; end
      4: begin s = 8'($urandom_range(1, 255)); e = 8'($urandom_range(0, s - 1)); end
      default: begin
        s = 8'($urandom_range(0, 230));
        e = s + 8'($urandom_range(0, 25));
      end
    endcase
    if (pick != 0) begin
      case ($urandom_range(0, 4))
        0: d = 8'd0;
        1: d = 8'd255;
        default: ;
      endcase
    end
    case ($urandom_range(0, 5))
      0: t = 8'd0;
      1: t = 8'd255;
      default: t = 8'($urandom_range(0, 255));
    endcase
    set_config(s, e, d, t);
  endtask

  task automatic test_random_sweeps();
    int n;
    while (active_items < ITEM_GOAL) begin
      random_config();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0)
          send_item($urandom_range(0, 1) ? OP_SAMPLE : OP_IGNORED,
                    8'($urandom_range(0, 255)));
        run_sweep($urandom_range(0, 1));
      end
    end
  endtask

  // Accept results after random stalls (when recv_idle is set) or a long hold, and check each one
  initial begin : result_receiver
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = recv_idle ? $urandom_range(0, 6) : 0;
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_duty_report(out_data);
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_items();
    test_peak_search();
    test_level_search();
    test_sweep_restart();
    test_register_extremes();
    test_receiver_hold();
    test_random_sweeps();
    wait_all_results();
    repeat (8) @(posedge clk);
    $display("summary: %0d sweep items and %0d ignored items sent, %0d results checked",
             active_items, ignored_items, reports_checked);
    $display("summary: %0d sweeps ended under %0d register settings, %0d mismatches",
             sweeps_ended, settings_applied, mismatches);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
